// ----- src/dda_pkg.sv -----
package dda_pkg;

   // fixed widths of the configuration registers and the input coordinates
   localparam int CFG_BITS = 13;
   localparam int IN_BITS  = 13;

   localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

   // configuration register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // request opcodes
   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_CLAMP     = 6'b000010,
      ST_SETUP     = 6'b000100,
      ST_DIV       = 6'b001000,
      ST_START_OUT = 6'b010000,
      ST_ADV       = 6'b100000
   } dda_state_type;

endpackage

// ----- src/dda_line_rasterizer_unit.sv -----
// DDA line rasterizer. A start word (opcode 0) carries both endpoints; each is clamped to
// the screen size held in the two configuration registers, and the response is the first
// pixel. Every advance word (opcode 1) then steps the major axis by one toward the second
// endpoint, adds the Q.16 slope to the minor accumulator and returns the next pixel, with
// line_done set on the last one; an advance with no line in progress returns a word with
// pixel_valid low. A start word is clamped, then its major axis is picked, then the restoring
// divider forms the slope one quotient bit per cycle, and the response is issued once the
// output register is free. A degenerate line skips the divider. An advance word also waits
// for a free output register before it issues its response. The request side accepts one
// word at a time, but a response waiting in the output register does not hold up the next
// request.
module dda_line_rasterizer_unit
   import dda_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_BITS-1:0]   csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [IN_BITS-1:0]    req_x_start,
   input  logic [IN_BITS-1:0]    req_y_start,
   input  logic [IN_BITS-1:0]    req_x_end,
   input  logic [IN_BITS-1:0]    req_y_end,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_valid,
   output logic                  rsp_line_done
);

   localparam int LIM_W = (CFG_BITS > COORD_BITS + 1) ? CFG_BITS : COORD_BITS + 1;
   localparam int NUM_W = COORD_BITS + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;

   localparam logic [LIM_W-1:0]        MAX_DIM = LIM_W'(1) << COORD_BITS;
   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] ONE     = ACC_W'(1) << FRAC_BITS;

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic [IN_BITS-1:0]  v,
      input logic [CFG_BITS-1:0] dim
   );
      logic [LIM_W-1:0] lim;
      logic [LIM_W-1:0] res;
      lim = LIM_W'(dim);
      if (lim == '0) begin
         lim = LIM_W'(1);
      end
      if (lim > MAX_DIM) begin
         lim = MAX_DIM;
      end
      res = (LIM_W'(v) >= lim) ? lim - LIM_W'(1) : LIM_W'(v);
      return res[COORD_BITS-1:0];
   endfunction

   dda_state_type state_ff, state_in;

   logic [CFG_BITS-1:0] screen_width_ff, screen_width_in;
   logic [CFG_BITS-1:0] screen_height_ff, screen_height_in;

   logic [IN_BITS-1:0] raw_x1_ff, raw_x1_in, raw_y1_ff, raw_y1_in;
   logic [IN_BITS-1:0] raw_x2_ff, raw_x2_in, raw_y2_ff, raw_y2_in;

   logic [COORD_BITS-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;

   logic [COORD_BITS-1:0] minor_start_ff, minor_start_in;
   logic                  minor_neg_ff, minor_neg_in;
   logic [COORD_BITS-1:0] major_len_ff, major_len_in;

   logic [NUM_W-1:0]      num_ff, num_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic                    line_active_ff, line_active_in;
   logic                    major_is_x_ff, major_is_x_in;
   logic                    step_neg_ff, step_neg_in;
   logic [COORD_BITS-1:0]   major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]   major_tgt_ff, major_tgt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] slope_ff, slope_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_pixel_x_ff, rsp_pixel_x_in;
   logic [COORD_BITS-1:0] rsp_pixel_y_ff, rsp_pixel_y_in;
   logic                  rsp_pixel_valid_ff, rsp_pixel_valid_in;
   logic                  rsp_line_done_ff, rsp_line_done_in;

   logic                    out_free;
   logic                    rsp_load;
   logic [COORD_BITS-1:0]   adx, ady;
   logic                    x_major;
   logic [COORD_BITS:0]     trial;
   logic                    trial_ge;
   logic [COORD_BITS-1:0]   rem_next;
   logic [NUM_W-1:0]        num_next;
   logic signed [ACC_W-1:0] slope_mag;
   logic signed [ACC_W-1:0] acc_next;
   logic [COORD_BITS-1:0]   minor_now;
   logic [COORD_BITS-1:0]   pos_next;
   logic                    pos_done;
   logic signed [ACC_W-1:0] slope_abs;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // axis selection from the clamped endpoints
   assign adx     = (x2_ff >= x1_ff) ? x2_ff - x1_ff : x1_ff - x2_ff;
   assign ady     = (y2_ff >= y1_ff) ? y2_ff - y1_ff : y1_ff - y2_ff;
   assign x_major = adx > ady;

   // one restoring divide step: a quotient bit shifts into num_ff as the dividend leaves
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge  = trial >= {1'b0, major_len_ff};
   assign rem_next  = trial_ge ? COORD_BITS'(trial - {1'b0, major_len_ff})
                               : trial[COORD_BITS-1:0];
   assign num_next  = {num_ff[NUM_W-2:0], trial_ge};
   assign slope_mag = ACC_W'(num_next[FRAC_BITS:0]);

   // advance step
   assign acc_next  = acc_ff + slope_ff;
   assign minor_now = acc_next[ACC_W-1] ? '0 : acc_next[FRAC_BITS +: COORD_BITS];
   assign pos_next  = step_neg_ff ? major_pos_ff - COORD_BITS'(1)
                                  : major_pos_ff + COORD_BITS'(1);
   assign pos_done  = (pos_next == major_tgt_ff);

   assign slope_abs = slope_ff[ACC_W-1] ? -slope_ff : slope_ff;

   always_comb begin
      state_in           = state_ff;
      screen_width_in    = screen_width_ff;
      screen_height_in   = screen_height_ff;
      raw_x1_in          = raw_x1_ff;
      raw_y1_in          = raw_y1_ff;
      raw_x2_in          = raw_x2_ff;
      raw_y2_in          = raw_y2_ff;
      x1_in              = x1_ff;
      y1_in              = y1_ff;
      x2_in              = x2_ff;
      y2_in              = y2_ff;
      minor_start_in     = minor_start_ff;
      minor_neg_in       = minor_neg_ff;
      major_len_in       = major_len_ff;
      num_in             = num_ff;
      rem_in             = rem_ff;
      cnt_in             = cnt_ff;
      line_active_in     = line_active_ff;
      major_is_x_in      = major_is_x_ff;
      step_neg_in        = step_neg_ff;
      major_pos_in       = major_pos_ff;
      major_tgt_in       = major_tgt_ff;
      acc_in             = acc_ff;
      slope_in           = slope_ff;
      rsp_load           = 1'b0;
      rsp_pixel_x_in     = rsp_pixel_x_ff;
      rsp_pixel_y_in     = rsp_pixel_y_ff;
      rsp_pixel_valid_in = rsp_pixel_valid_ff;
      rsp_line_done_in   = rsp_line_done_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_x1_in = req_x_start;
               raw_y1_in = req_y_start;
               raw_x2_in = req_x_end;
               raw_y2_in = req_y_end;
               state_in  = (req_opcode == OP_START) ? ST_CLAMP : ST_ADV;
            end
         end
         ST_CLAMP: begin
            x1_in    = clamp_coord(raw_x1_ff, screen_width_ff);
            y1_in    = clamp_coord(raw_y1_ff, screen_height_ff);
            x2_in    = clamp_coord(raw_x2_ff, screen_width_ff);
            y2_in    = clamp_coord(raw_y2_ff, screen_height_ff);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            major_is_x_in = x_major;
            if (x_major) begin
               major_pos_in   = x1_ff;
               major_tgt_in   = x2_ff;
               step_neg_in    = x2_ff < x1_ff;
               minor_neg_in   = y2_ff < y1_ff;
               minor_start_in = y1_ff;
               major_len_in   = adx;
               num_in         = NUM_W'(ady) << FRAC_BITS;
            end else begin
               major_pos_in   = y1_ff;
               major_tgt_in   = y2_ff;
               step_neg_in    = y2_ff < y1_ff;
               minor_neg_in   = x2_ff < x1_ff;
               minor_start_in = x1_ff;
               major_len_in   = ady;
               num_in         = NUM_W'(adx) << FRAC_BITS;
            end
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
            // both endpoints equal: no slope needed
            state_in = ((x_major ? adx : ady) == '0) ? ST_START_OUT : ST_DIV;
         end
         ST_DIV: begin
            rem_in = rem_next;
            num_in = num_next;
            if (cnt_ff == '0) begin
               slope_in = minor_neg_ff ? -slope_mag : slope_mag;
               state_in = ST_START_OUT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_START_OUT: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_pixel_x_in     = x1_ff;
               rsp_pixel_y_in     = y1_ff;
               rsp_pixel_valid_in = 1'b1;
               if (major_len_ff == '0) begin
                  rsp_line_done_in = 1'b1;
                  line_active_in   = 1'b0;
                  slope_in         = '0;
                  acc_in           = '0;
               end else begin
                  rsp_line_done_in = 1'b0;
                  line_active_in   = 1'b1;
                  acc_in           = (ACC_W'(minor_start_ff) << FRAC_BITS) + HALF;
               end
               state_in = ST_IDLE;
            end
         end
         ST_ADV: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (line_active_ff) begin
                  major_pos_in       = pos_next;
                  acc_in             = acc_next;
                  line_active_in     = !pos_done;
                  rsp_pixel_x_in     = major_is_x_ff ? pos_next : minor_now;
                  rsp_pixel_y_in     = major_is_x_ff ? minor_now : pos_next;
                  rsp_pixel_valid_in = 1'b1;
                  rsp_line_done_in   = pos_done;
               end else begin
                  rsp_pixel_x_in     = '0;
                  rsp_pixel_y_in     = '0;
                  rsp_pixel_valid_in = 1'b0;
                  rsp_line_done_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         line_active_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         line_active_ff   <= line_active_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_x1_ff          <= raw_x1_in;
      raw_y1_ff          <= raw_y1_in;
      raw_x2_ff          <= raw_x2_in;
      raw_y2_ff          <= raw_y2_in;
      x1_ff              <= x1_in;
      y1_ff              <= y1_in;
      x2_ff              <= x2_in;
      y2_ff              <= y2_in;
      minor_start_ff     <= minor_start_in;
      minor_neg_ff       <= minor_neg_in;
      major_len_ff       <= major_len_in;
      num_ff             <= num_in;
      rem_ff             <= rem_in;
      cnt_ff             <= cnt_in;
      major_is_x_ff      <= major_is_x_in;
      step_neg_ff        <= step_neg_in;
      major_pos_ff       <= major_pos_in;
      major_tgt_ff       <= major_tgt_in;
      acc_ff             <= acc_in;
      slope_ff           <= slope_in;
      rsp_pixel_x_ff     <= rsp_pixel_x_in;
      rsp_pixel_y_ff     <= rsp_pixel_y_in;
      rsp_pixel_valid_ff <= rsp_pixel_valid_in;
      rsp_line_done_ff   <= rsp_line_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_pixel_valid = rsp_pixel_valid_ff;
   assign rsp_line_done   = rsp_line_done_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (major_len_ff != '0))
      else $error("divider running with a zero major length");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < major_len_ff))
      else $error("divider remainder not below divisor");

   a_done_ends_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_line_done_in) |=> !line_active_ff)
      else $error("line still active after its last pixel");

   a_slope_bound: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (slope_abs <= ONE))
      else $error("slope magnitude above one pixel per step");

endmodule
